[rtl/core/kdlr_pkg.sv]
// ----------------------------------------------------------------------------
// kdlr_pkg: shared types, constants and key tables
// Key table contents, per-key state layout and keystroke record for the
// keypad debounce / layer / repeat scanner.
// ----------------------------------------------------------------------------
package kdlr_pkg;

  localparam int NUM_KEYS    = 11;
  localparam int TIME_WIDTH  = 32;
  localparam int TABLE_KEYS  = 11;
  localparam int LAYER_BIT   = 11;
  localparam int LEVELS_W    = 12;
  localparam int NOW_W       = 32;
  localparam int CFG_W       = 16;
  localparam int KEY_INDEX_W = 4;
  localparam int BYTE_W      = 8;

  // Keys beyond the table are never walked.
  localparam int KEY_CNT   = (NUM_KEYS < TABLE_KEYS) ? NUM_KEYS : TABLE_KEYS;
  localparam int KEY_IDX_W = (KEY_CNT > 1) ? $clog2(KEY_CNT) : 1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = CFG_W'(50);
  localparam logic [CFG_W-1:0] HOLD_RST     = CFG_W'(1000);

  // Register indexes on the configuration port.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD     = 1'b1;

  localparam logic [BYTE_W-1:0] CTRL_MOD  = 8'h80;
  localparam logic [BYTE_W-1:0] SHIFT_MOD = 8'h81;
  localparam logic [BYTE_W-1:0] ALT_MOD   = 8'h82;

  localparam logic [BYTE_W-1:0] PRIM_CODE [TABLE_KEYS] = '{
    8'd50, 8'd91, 8'd99, 8'd45, 8'd52, 8'd92, 8'd99, 8'd43, 8'd54, 8'd93, 8'd116
  };
  localparam logic [BYTE_W-1:0] PRIM_M1 [TABLE_KEYS] = '{
    SHIFT_MOD, SHIFT_MOD, CTRL_MOD, CTRL_MOD, SHIFT_MOD, CTRL_MOD,
    SHIFT_MOD, CTRL_MOD, SHIFT_MOD, SHIFT_MOD, CTRL_MOD
  };
  localparam logic [BYTE_W-1:0] PRIM_M2 [TABLE_KEYS] = '{
    8'd0, 8'd0, SHIFT_MOD, ALT_MOD, 8'd0, 8'd0, 8'd0, SHIFT_MOD, 8'd0, 8'd0, 8'd0
  };
  localparam logic [BYTE_W-1:0] ALT_CODE [TABLE_KEYS] = '{
    8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106, 8'd107
  };
  localparam logic [BYTE_W-1:0] ALT_M1 [TABLE_KEYS] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };
  localparam logic [BYTE_W-1:0] ALT_M2 [TABLE_KEYS] = '{
    8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  typedef struct packed {
    logic [TIME_WIDTH-1:0] press_time;
    logic [TIME_WIDTH-1:0] hold_time;
    logic                  prev_level;
  } key_state_t;

  localparam key_state_t KEY_STATE_RST = '{
    press_time: '0,
    hold_time:  '0,
    prev_level: 1'b1
  };

  typedef struct packed {
    logic [KEY_INDEX_W-1:0] key_index;
    logic [BYTE_W-1:0]      key_code;
    logic [BYTE_W-1:0]      first_mod;
    logic [BYTE_W-1:0]      second_mod;
  } stroke_t;

  typedef struct packed {
    logic                  rd_en;
    logic [KEY_IDX_W-1:0]  rd_addr;
    logic                  wr_en;
    logic [KEY_IDX_W-1:0]  wr_addr;
  } mem_ctrl_t;

endpackage

[rtl/core/kdlr_key_mem.sv]
// ----------------------------------------------------------------------------
// kdlr_key_mem: per-key state memory
// One entry per key, registered read; unwritten entries read as
// the reset state through a row of valid bits cleared by reset.
// ----------------------------------------------------------------------------
module kdlr_key_mem (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  kdlr_pkg::mem_ctrl_t    ctrl_i,
  input  kdlr_pkg::key_state_t   wr_data_i,
  output kdlr_pkg::key_state_t   rd_data_o
);

  kdlr_pkg::key_state_t mem_q [kdlr_pkg::KEY_CNT];
  kdlr_pkg::key_state_t rd_q;
  logic [kdlr_pkg::KEY_CNT-1:0] vld_q;
  logic                         rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[ctrl_i.wr_addr] <= wr_data_i;
    end
    if (ctrl_i.rd_en) begin
      rd_q <= mem_q[ctrl_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctrl_i.wr_en) begin
        vld_q[ctrl_i.wr_addr] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_vld_q <= vld_q[ctrl_i.rd_addr];
      end
    end
  end

  // Substitute the reset state for entries never written.
  assign rd_data_o = rd_vld_q ? rd_q : kdlr_pkg::KEY_STATE_RST;

endmodule

[rtl/core/kdlr_key_eval.sv]
// ----------------------------------------------------------------------------
// kdlr_key_eval: one key's debounce and hold decision
// Compares the scan time against the stored press and hold times, builds the
// keystroke from the layer tables and forms the state to write back.
// ----------------------------------------------------------------------------
module kdlr_key_eval (
  input  logic [kdlr_pkg::KEY_IDX_W-1:0]  key_i,
  input  logic                            level_i,
  input  logic                            alt_i,
  input  logic [kdlr_pkg::TIME_WIDTH-1:0] now_i,
  input  logic [kdlr_pkg::CFG_W-1:0]      debounce_i,
  input  logic [kdlr_pkg::CFG_W-1:0]      hold_i,
  input  kdlr_pkg::key_state_t            state_i,
  output kdlr_pkg::key_state_t            state_o,
  output logic                            emit_o,
  output kdlr_pkg::stroke_t               stroke_o
);

  logic                            changed;
  logic                            press_ok;
  logic                            held_ok;
  logic [kdlr_pkg::TIME_WIDTH-1:0] hold_base;
  logic [kdlr_pkg::TIME_WIDTH-1:0] press_delta;
  logic [kdlr_pkg::TIME_WIDTH-1:0] hold_delta;
  logic [kdlr_pkg::BYTE_W-1:0]     m1;
  logic [kdlr_pkg::BYTE_W-1:0]     m2;

  always_comb begin
    changed     = (level_i != state_i.prev_level);
    press_delta = now_i - state_i.press_time;
    press_ok    = changed && !level_i &&
                  (press_delta >= kdlr_pkg::TIME_WIDTH'(debounce_i));
    // Restart the hold timer on any change and while released.
    hold_base   = (changed || level_i) ? now_i : state_i.hold_time;
    hold_delta  = now_i - hold_base;
    held_ok     = !level_i && !press_ok &&
                  (hold_delta >= kdlr_pkg::TIME_WIDTH'(hold_i)) &&
                  (kdlr_pkg::PRIM_M1[key_i] == '0);
    emit_o      = press_ok || held_ok;

    state_o.press_time = press_ok ? now_i : state_i.press_time;
    state_o.hold_time  = hold_base;
    state_o.prev_level = level_i;

    m1 = alt_i ? kdlr_pkg::ALT_M1[key_i] : kdlr_pkg::PRIM_M1[key_i];
    m2 = alt_i ? kdlr_pkg::ALT_M2[key_i] : kdlr_pkg::PRIM_M2[key_i];
    stroke_o.key_index  = kdlr_pkg::KEY_INDEX_W'(key_i);
    stroke_o.key_code   = alt_i ? kdlr_pkg::ALT_CODE[key_i] : kdlr_pkg::PRIM_CODE[key_i];
    stroke_o.first_mod  = m1;
    stroke_o.second_mod = (m1 != '0) ? m2 : '0;
  end

endmodule

[rtl/core/keypad_debounce_layer_repeat_core.sv]
// ----------------------------------------------------------------------------
// keypad_debounce_layer_repeat_core: keypad scan with debounce, layer, repeat
// Scans: a new scan is accepted only in idle, once the previous key walk and
//   flush are done; the walk reads one state-memory entry per cycle unless
//   output stalls hold it. Keystrokes pass through a pending register and
//   then the output register.
// Reset: state memory reads released/zero times, timers back to 50 and 1000.
// ----------------------------------------------------------------------------
module keypad_debounce_layer_repeat_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [kdlr_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [kdlr_pkg::CFG_W-1:0]        cfg_data_i,
  // scan requests
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [kdlr_pkg::NOW_W-1:0]        now_ms_i,
  input  logic [kdlr_pkg::LEVELS_W-1:0]     key_levels_i,
  // keystroke requests
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [kdlr_pkg::KEY_INDEX_W-1:0]  key_index_o,
  output logic [kdlr_pkg::BYTE_W-1:0]       key_code_o,
  output logic [kdlr_pkg::BYTE_W-1:0]       first_modifier_o,
  output logic [kdlr_pkg::BYTE_W-1:0]       second_modifier_o,
  output logic                              last_of_scan_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_CALC  = 3'b010,
    ST_FLUSH = 3'b100
  } state_e;

  localparam logic [kdlr_pkg::KEY_IDX_W-1:0] KEY_LAST =
    kdlr_pkg::KEY_IDX_W'(kdlr_pkg::KEY_CNT - 1);

  state_e st_q, st_d;

  // Configuration registers.
  logic [kdlr_pkg::CFG_W-1:0] debounce_q;
  logic [kdlr_pkg::CFG_W-1:0] hold_q;

  // Scan capture.
  logic [kdlr_pkg::TIME_WIDTH-1:0] now_q, now_d;
  logic [kdlr_pkg::LEVELS_W-1:0]   lvl_q, lvl_d;
  logic [kdlr_pkg::KEY_IDX_W-1:0]  key_q, key_d;

  // One keystroke is held back until it is known whether it ends the scan.
  kdlr_pkg::stroke_t pend_q, pend_d;
  logic              pend_vld_q, pend_vld_d;

  // Output register.
  kdlr_pkg::stroke_t out_q, out_d;
  logic              out_last_q, out_last_d;
  logic              out_vld_q, out_vld_d;
  logic              out_free;

  logic                 in_accept;
  logic                 adv;
  logic                 emit;
  kdlr_pkg::stroke_t    stroke;
  kdlr_pkg::key_state_t rd_state;
  kdlr_pkg::key_state_t wr_state;
  kdlr_pkg::mem_ctrl_t  mem_ctrl;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= kdlr_pkg::DEBOUNCE_RST;
      hold_q     <= kdlr_pkg::HOLD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        kdlr_pkg::CFG_DEBOUNCE: debounce_q <= cfg_data_i;
        kdlr_pkg::CFG_HOLD:     hold_q     <= cfg_data_i;
        default:                ;
      endcase
    end
  end

  kdlr_key_mem u_key_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (mem_ctrl),
    .wr_data_i (wr_state),
    .rd_data_o (rd_state)
  );

  kdlr_key_eval u_key_eval (
    .key_i      (key_q),
    .level_i    (lvl_q[key_q]),
    .alt_i      (!lvl_q[kdlr_pkg::LAYER_BIT]),
    .now_i      (now_q),
    .debounce_i (debounce_q),
    .hold_i     (hold_q),
    .state_i    (rd_state),
    .state_o    (wr_state),
    .emit_o     (emit),
    .stroke_o   (stroke)
  );

  assign in_stall_o = (st_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_vld_q || !out_stall_i;
  // Stall the walk only when a new keystroke would displace a pending one
  // and the output register cannot take it.
  assign adv        = !(emit && pend_vld_q) || out_free;

  always_comb begin
    st_d       = st_q;
    now_d      = now_q;
    lvl_d      = lvl_q;
    key_d      = key_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_d      = out_q;
    out_last_d = out_last_q;
    out_vld_d  = out_free ? 1'b0 : out_vld_q;

    mem_ctrl.rd_en   = 1'b0;
    mem_ctrl.rd_addr = key_q + 1'b1;
    mem_ctrl.wr_en   = 1'b0;
    mem_ctrl.wr_addr = key_q;

    unique case (st_q)
      ST_IDLE: begin
        if (in_accept) begin
          now_d            = now_ms_i[kdlr_pkg::TIME_WIDTH-1:0];
          lvl_d            = key_levels_i;
          key_d            = '0;
          mem_ctrl.rd_en   = 1'b1;
          mem_ctrl.rd_addr = '0;
          st_d             = ST_CALC;
        end
      end
      ST_CALC: begin
        if (adv) begin
          mem_ctrl.wr_en = 1'b1;
          if (emit) begin
            // Push the older keystroke out; it is not the last of the scan.
            if (pend_vld_q) begin
              out_d      = pend_q;
              out_last_d = 1'b0;
              out_vld_d  = 1'b1;
            end
            pend_d     = stroke;
            pend_vld_d = 1'b1;
          end
          if (key_q == KEY_LAST) begin
            st_d = ST_FLUSH;
          end else begin
            key_d          = key_q + 1'b1;
            mem_ctrl.rd_en = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_vld_q) begin
          st_d = ST_IDLE;
        end else if (out_free) begin
          out_d      = pend_q;
          out_last_d = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
          st_d       = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_IDLE;
      key_q      <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      st_q       <= st_d;
      key_q      <= key_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q      <= now_d;
    lvl_q      <= lvl_d;
    pend_q     <= pend_d;
    out_q      <= out_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o       = out_vld_q;
  assign key_index_o       = out_q.key_index;
  assign key_code_o        = out_q.key_code;
  assign first_modifier_o  = out_q.first_mod;
  assign second_modifier_o = out_q.second_mod;
  assign last_of_scan_o    = out_last_q;

  // A scan always leaves nothing pending once the walker is back in idle.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> !pend_vld_q)
    else $error("keystroke left pending after scan end");

  // State memory is written only while walking keys.
  a_write_in_calc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctrl.wr_en |-> (st_q == ST_CALC))
    else $error("state memory written outside key walk");

  // The walk counter stays inside the table.
  a_key_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CALC) |-> (key_q <= KEY_LAST))
    else $error("key counter beyond last key");

  // A held keystroke displaced into a full, stalled output would be lost.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_stall_i) |=> (out_vld_q && $stable(out_q) && $stable(out_last_q)))
    else $error("stalled keystroke overwritten");

  // The last keystroke of a scan returns the walker to idle.
  a_last_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_FLUSH && pend_vld_q && out_free) |=> (st_q == ST_IDLE && out_last_q))
    else $error("final keystroke not marked or scan not closed");

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: keypad scan core with debounce, layer key and hold repeat
// A request queue feeds scans, register writes and drain points to a clocked
// driver. Every accepted scan is run through a local keystroke predictor, and
// a clocked monitor checks each keystroke request against the oldest one due.
// ----------------------------------------------------------------------------
module testbench;
  import kdlr_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 32;    // settle time after the last accepted scan
  localparam int PHASE_SCANS   = 125;

  // What one entry of the request queue asks the driver to do.
  typedef enum logic [1:0] {
    REQ_SCAN,   // present one scan request
    REQ_CFG,    // write one register
    REQ_DRAIN,  // hold off until every due keystroke is back and the core is quiet
    REQ_MODE    // switch the idle / stall percentages
  } req_kind_e;

  typedef struct {
    req_kind_e             kind;
    logic [NOW_W-1:0]      now;
    logic [LEVELS_W-1:0]   levels;
    logic [CFG_IDX_W-1:0]  reg_index;
    logic [CFG_W-1:0]      reg_data;
    int                    gap_pct;
    int                    stall_pct;
  } request_t;

  typedef struct packed {
    logic [KEY_INDEX_W-1:0] key_index;
    logic [BYTE_W-1:0]      key_code;
    logic [BYTE_W-1:0]      first_mod;
    logic [BYTE_W-1:0]      second_mod;
    logic                   last;
  } keystroke_t;

  // Clock, reset and core ports; every input starts at a known value.
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    cfg_valid_i  = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i  = CFG_DEBOUNCE;
  logic [CFG_W-1:0]        cfg_data_i   = '0;
  logic                    in_valid_i   = 1'b0;
  logic                    in_stall_o;
  logic [NOW_W-1:0]        now_ms_i     = '0;
  logic [LEVELS_W-1:0]     key_levels_i = '1;
  logic                    out_valid_o;
  logic                    out_stall_i  = 1'b0;
  logic [KEY_INDEX_W-1:0]  key_index_o;
  logic [BYTE_W-1:0]       key_code_o;
  logic [BYTE_W-1:0]       first_modifier_o;
  logic [BYTE_W-1:0]       second_modifier_o;
  logic                    last_of_scan_o;

  // Request queue, keystrokes still due, and run bookkeeping.
  request_t   scan_queue [$];
  keystroke_t due_strokes [$];
  int         gap_pct     = 0;
  int         stall_pct   = 0;
  int         since_scan  = SETTLE_CYCLES;
  int         error_count = 0;
  int         cycle_count = 0;
  logic       scan_busy   = 1'b0;
  logic       cfg_busy    = 1'b0;

  // Predictor copy of the registers and of the per-key state.
  logic [CFG_W-1:0]      debounce_cfg = DEBOUNCE_RST;
  logic [CFG_W-1:0]      hold_cfg     = HOLD_RST;
  logic [TIME_WIDTH-1:0] press_at   [KEY_CNT];
  logic [TIME_WIDTH-1:0] held_since [KEY_CNT];
  logic                  last_level [KEY_CNT];

  keypad_debounce_layer_repeat_core u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .now_ms_i          (now_ms_i),
    .key_levels_i      (key_levels_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .key_index_o       (key_index_o),
    .key_code_o        (key_code_o),
    .first_modifier_o  (first_modifier_o),
    .second_modifier_o (second_modifier_o),
    .last_of_scan_o    (last_of_scan_o)
  );

  always #4 clk_i = ~clk_i;

  // Build one keystroke from the layer selected by this scan. The second
  // modifier only goes out when a first modifier is present.
  function automatic keystroke_t make_stroke(int k, logic alt_layer);
    keystroke_t ks;
    ks.key_index  = KEY_INDEX_W'(k);
    ks.key_code   = alt_layer ? ALT_CODE[k] : PRIM_CODE[k];
    ks.first_mod  = alt_layer ? ALT_M1[k] : PRIM_M1[k];
    ks.second_mod = (ks.first_mod != '0) ? (alt_layer ? ALT_M2[k] : PRIM_M2[k]) : '0;
    ks.last       = 1'b0;
    return ks;
  endfunction

  // Walk the keys of one accepted scan in order and queue the keystrokes it
  // must produce; flag the final one of the scan.
  task automatic predict_keystrokes(input logic [NOW_W-1:0] now,
                                    input logic [LEVELS_W-1:0] levels);
    keystroke_t            batch [$];
    logic                  alt_layer;
    logic                  lvl;
    logic                  hit;
    logic [TIME_WIDTH-1:0] gap;
    alt_layer = ~levels[LAYER_BIT];
    for (int k = 0; k < KEY_CNT; k++) begin
      lvl = levels[k];
      hit = 1'b0;
      if (lvl != last_level[k]) begin
        // Any level change restarts the hold timer.
        held_since[k] = now;
        if (!lvl) begin
          gap = now - press_at[k];
          if (gap >= TIME_WIDTH'(debounce_cfg)) begin
            batch.push_back(make_stroke(k, alt_layer));
            press_at[k] = now;
            hit = 1'b1;
          end
        end
      end
      if (!lvl) begin
        // Held key: repeat only for keys without a primary first modifier,
        // and never on top of an edge keystroke in the same scan.
        gap = now - held_since[k];
        if (!hit && gap >= TIME_WIDTH'(hold_cfg) && PRIM_M1[k] == '0) begin
          batch.push_back(make_stroke(k, alt_layer));
        end
      end else begin
        held_since[k] = now;
      end
      last_level[k] = lvl;
    end
    if (batch.size() != 0) begin
      batch[batch.size()-1].last = 1'b1;
    end
    foreach (batch[i]) begin
      due_strokes.push_back(batch[i]);
    end
  endtask

  task automatic check_field(input string name, input logic [BYTE_W-1:0] want_v,
                             input logic [BYTE_W-1:0] got_v);
    if (want_v !== got_v) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // Driver: take the head of the request queue once the previous request is
  // gone. Register writes and drains only ever sit between scans, so the core
  // is idle whenever a register changes.
  always @(posedge clk_i) begin : driver
    request_t req;
    logic     scan_v;
    logic     cfg_v;
    if (!rst_ni) begin
      for (int k = 0; k < KEY_CNT; k++) begin
        press_at[k]   = '0;
        held_since[k] = '0;
        last_level[k] = 1'b1;
      end
      debounce_cfg = DEBOUNCE_RST;
      hold_cfg     = HOLD_RST;
      since_scan   = SETTLE_CYCLES;
      scan_busy    = 1'b0;
      cfg_busy     = 1'b0;
      in_valid_i  <= 1'b0;
      cfg_valid_i <= 1'b0;
    end else begin
      // Predict on the edge that accepts the scan.
      if (in_valid_i && !in_stall_o) begin
        predict_keystrokes(now_ms_i, key_levels_i);
        scan_busy  = 1'b0;
        since_scan = 0;
      end else if (since_scan < SETTLE_CYCLES) begin
        since_scan++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_DEBOUNCE: debounce_cfg = cfg_data_i;
          CFG_HOLD:     hold_cfg     = cfg_data_i;
          default: ;
        endcase
        cfg_busy = 1'b0;
      end
      // Keep a pending request up; otherwise pick the next one. Compute each
      // valid once so it gets a single assignment per edge.
      scan_v = scan_busy;
      cfg_v  = cfg_busy;
      if (!scan_busy && !cfg_busy && scan_queue.size() != 0) begin
        req = scan_queue[0];
        case (req.kind)
          REQ_MODE: begin
            gap_pct   = req.gap_pct;
            stall_pct = req.stall_pct;
            scan_queue.delete(0);
          end
          REQ_DRAIN: begin
            if (due_strokes.size() == 0 && since_scan >= SETTLE_CYCLES) begin
              scan_queue.delete(0);
            end
          end
          REQ_CFG: begin
            cfg_index_i <= req.reg_index;
            cfg_data_i  <= req.reg_data;
            cfg_v        = 1'b1;
            cfg_busy     = 1'b1;
            scan_queue.delete(0);
          end
          REQ_SCAN: begin
            // Idle the sender at random between scans.
            if ($urandom_range(99) >= gap_pct) begin
              now_ms_i     <= req.now;
              key_levels_i <= req.levels;
              scan_v        = 1'b1;
              scan_busy     = 1'b1;
              scan_queue.delete(0);
            end
          end
          default: scan_queue.delete(0);
        endcase
      end
      in_valid_i  <= scan_v;
      cfg_valid_i <= cfg_v;
    end
  end

  // Monitor: check each accepted keystroke request, then pick the next stall.
  always @(posedge clk_i) begin : monitor
    keystroke_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (due_strokes.size() == 0) begin
          error_count++;
          $display("%0t: keystroke with none due, expected nothing, actual key %0d code %0d",
                   $time, key_index_o, key_code_o);
        end else begin
          want = due_strokes.pop_front();
          check_field("key_index", BYTE_W'(want.key_index), BYTE_W'(key_index_o));
          check_field("key_code", want.key_code, key_code_o);
          check_field("first_modifier", want.first_mod, first_modifier_o);
          check_field("second_modifier", want.second_mod, second_modifier_o);
          check_field("last_of_scan", BYTE_W'(want.last), BYTE_W'(last_of_scan_o));
        end
      end
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  // Stop a hung run.
  always @(posedge clk_i) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  task automatic add_scan(input logic [NOW_W-1:0] now, input logic [LEVELS_W-1:0] levels);
    request_t req;
    req = '{kind: REQ_SCAN, now: now, levels: levels, reg_index: CFG_DEBOUNCE,
            reg_data: '0, gap_pct: 0, stall_pct: 0};
    scan_queue.push_back(req);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    request_t req;
    req = '{kind: REQ_CFG, now: '0, levels: '1, reg_index: idx,
            reg_data: data, gap_pct: 0, stall_pct: 0};
    scan_queue.push_back(req);
  endtask

  task automatic add_marker(input req_kind_e kind, input int gap, input int stall);
    request_t req;
    req = '{kind: kind, now: '0, levels: '1, reg_index: CFG_DEBOUNCE,
            reg_data: '0, gap_pct: gap, stall_pct: stall};
    scan_queue.push_back(req);
  endtask

  initial begin : stimulus
    logic [NOW_W-1:0]    t;
    logic [LEVELS_W-1:0] lv;
    int                  roll;
    int                  phase_gap [4];
    int                  phase_stall [4];
    phase_gap   = '{0, 73, 0, 18};
    phase_stall = '{0, 0, 73, 18};

    // Directed part, starting from the reset timers (debounce 50, hold 1000).
    add_marker(REQ_MODE, 0, 0);
    add_scan(32'd10, 12'hFFF);              // all released, nothing out
    add_scan(32'd20, 12'h800);              // press too soon after time zero
    add_scan(32'd30, 12'hFFF);
    add_scan(32'd100, 12'h800);             // all eleven keys, primary layer
    add_scan(32'd120, 12'hFFF);
    add_scan(32'd140, 12'h000);             // bounce inside debounce window
    add_scan(32'd151, 12'h7FF);
    add_scan(32'd160, 12'h000);             // all eleven keys, alternate layer
    add_scan(32'd2000, 12'h000);            // held past the hold time
    add_scan(32'd2001, 12'hFFF);
    add_scan(32'hFFFF_FFF0, 12'h800);       // top of the time range
    add_scan(32'hFFFF_FFF8, 12'hFFF);
    add_scan(32'h0000_0010, 12'h800);       // wrapped gap still short
    add_scan(32'h0000_0020, 12'hFFF);
    add_scan(32'h0000_0030, 12'hFFE);       // single key, single keystroke
    // Zero timers: every edge counts, the hold time is met at once.
    add_marker(REQ_DRAIN, 0, 0);
    add_cfg(CFG_DEBOUNCE, 16'h0000);
    add_cfg(CFG_HOLD, 16'h0000);
    add_scan(32'h0000_0030, 12'h800);
    add_scan(32'h0000_0030, 12'hFFF);
    add_scan(32'h0000_0030, 12'h000);
    // Full-scale timers.
    add_marker(REQ_DRAIN, 0, 0);
    add_cfg(CFG_DEBOUNCE, 16'hFFFF);
    add_cfg(CFG_HOLD, 16'hFFFF);
    add_scan(32'h0000_1000, 12'hFFF);
    add_scan(32'h0001_1000, 12'h800);
    add_scan(32'h0001_1001, 12'hFFF);
    add_scan(32'h0001_1002, 12'h800);       // second press far inside window

    // Random part: mostly key sequences that evolve a few keys at a time on a
    // slowly rising clock, with jumps in time and noise scans mixed in.
    t  = 32'h0001_1002;
    lv = 12'hFFF;
    for (int p = 0; p < 4; p++) begin
      add_marker(REQ_DRAIN, 0, 0);
      add_cfg(CFG_DEBOUNCE, CFG_W'($urandom_range(0, 60)));
      add_cfg(CFG_HOLD, CFG_W'($urandom_range(0, 65535)));
      add_marker(REQ_MODE, phase_gap[p], phase_stall[p]);
      for (int i = 0; i < PHASE_SCANS; i++) begin
        // Pause the sender mid-phase until everything due has come back.
        if (i == PHASE_SCANS / 2) begin
          add_marker(REQ_DRAIN, 0, 0);
        end
        roll = $urandom_range(99);
        if (roll < 4) begin
          t = $urandom;
        end else if (roll >= 8) begin
          t = t + NOW_W'($urandom_range(1, 40));
        end
        roll = $urandom_range(99);
        if (roll < 10) begin
          lv = LEVELS_W'($urandom);
        end else begin
          for (int k = 0; k < KEY_CNT; k++) begin
            if ($urandom_range(99) < 30) begin
              lv[k] = ~lv[k];
            end
          end
          if ($urandom_range(99) < 20) begin
            lv[LAYER_BIT] = ~lv[LAYER_BIT];
          end
        end
        add_scan(t, lv);
      end
    end
    add_marker(REQ_DRAIN, 0, 0);

    // Hold reset, then release it for good.
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain everything, then give the core time to show any stray keystroke.
    while (scan_queue.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && due_strokes.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
